/* hw/rtl/aef_pkg.sv */
// Shared types and constants for the audio envelope follower.
package aef_pkg;

  // Default build parameters
  localparam int CHUNK_SAMPLES_DEF  = 240;
  localparam int AUDIO_RATE_HZ_DEF  = 48000;

  // Fixed point: 65536 is 1.0
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam int          MS_PER_S = 1000;

  // Cycle counts of the serial arithmetic units
  localparam logic [4:0] MUL_STEPS      = 5'd16;
  localparam logic [4:0] DIV_RAW_STEPS  = 5'd17;
  localparam logic [4:0] DIV_TIME_STEPS = 5'd18;

  // Configuration register indexes
  localparam logic [2:0] CFG_NORM_DIVISOR      = 3'd0;
  localparam logic [2:0] CFG_FAST_ATTACK_COEF  = 3'd1;
  localparam logic [2:0] CFG_FAST_RELEASE_COEF = 3'd2;
  localparam logic [2:0] CFG_SLOW_COEF         = 3'd3;
  localparam logic [2:0] CFG_ONSET_SLOW_SCALE  = 3'd4;
  localparam logic [2:0] CFG_ONSET_GAIN        = 3'd5;

  // Configuration reset values
  localparam logic [15:0] NORM_DIVISOR_RST      = 16'd9000;
  localparam logic [15:0] FAST_ATTACK_COEF_RST  = 16'd31457;
  localparam logic [15:0] FAST_RELEASE_COEF_RST = 16'd7864;
  localparam logic [15:0] SLOW_COEF_RST         = 16'd2294;
  localparam logic [15:0] ONSET_SLOW_SCALE_RST  = 16'd17695;
  localparam logic [15:0] ONSET_GAIN_RST        = 16'd13107;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN,
    ST_RAW_DIV,
    ST_FAST,
    ST_SLOW,
    ST_SCALE,
    ST_ONSET,
    ST_TIME,
    ST_EMIT
  } state_t;

endpackage

/* hw/rtl/audio_envelope_follower.sv */
// Envelope follower with a shared shift-add multiplier and restoring divider.
// A sample that does not end a chunk leaves the block idle, so in_ready is high again next cycle.
// out_valid rises after a chunk-ending transfer once the sequence completes: five multiplies and
// two divisions, or one division when the normalised level saturates, then ST_EMIT.
// The input waits during that sequence, and longer while an earlier result is still held.
// Synchronous reset restores the configuration defaults and clears envelopes, counts and time.
module audio_envelope_follower #(
  parameter int CHUNK_SAMPLES = aef_pkg::CHUNK_SAMPLES_DEF,
  parameter int AUDIO_RATE_HZ = aef_pkg::AUDIO_RATE_HZ_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample,
  input  logic               chunk_last,
  input  logic               sound_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        level,
  output logic [16:0]        attack,
  output logic [31:0]        elapsed_time
);
  import aef_pkg::*;

  // Configuration
  logic [15:0] norm_divisor, fast_attack_coef, fast_release_coef;
  logic [15:0] slow_coef, onset_slow_scale, onset_gain;

  // Follower state
  logic [22:0] acc;
  logic [7:0]  cnt;
  logic [16:0] fast, slow, raw, onset;
  logic [31:0] elapsed;
  logic        up;

  // Serial units
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] prod;
  logic [24:0] div_r;
  logic [17:0] div_d;
  logic [23:0] div_v;
  logic [17:0] div_q;
  logic [4:0]  step;

  state_t state, state_next;
  logic   step_done, emit_fire, accept, chunk_end;

  // Combinational datapath
  logic [15:0] mag;
  logic [22:0] acc_new;
  logic [7:0]  cnt_new;
  logic [17:0] mul_sum;
  logic [24:0] div_sh, div_sub;
  logic        div_ge;
  logic        raw_sat;
  logic [16:0] raw_in, fast_diff, slow_diff, delta, fast_upd, slow_upd, onset_diff;
  logic        fast_up, slow_up, onset_gt;
  logic [18:0] scaled;
  logic [20:0] onset_raw;
  logic [16:0] onset_sat;
  logic [17:0] time_num;

  assign cfg_ready = 1'b1;
  assign step_done = (step == '0);
  assign accept    = in_valid && in_ready;

  always_comb begin
    mag     = sample[15] ? 16'(~sample + 16'sd1) : 16'(sample);
    acc_new = (sound_start ? 23'd0 : acc) + 23'(mag);
    cnt_new = (sound_start ? 8'd0 : cnt) + 8'd1;
    chunk_end = chunk_last || (cnt_new >= 8'(CHUNK_SAMPLES));

    mul_sum = {1'b0, prod[32:16]} + (mul_b[0] ? {1'b0, mul_a} : 18'd0);

    div_sh  = {div_r[23:0], div_d[17]};
    div_ge  = div_sh >= {1'b0, div_v};
    div_sub = div_sh - {1'b0, div_v};

    // Quotient of at least two (or a zero denominator) always clamps to 1.0.
    raw_sat = {2'b0, acc} >= {prod[23:0], 1'b0};
    if (state == ST_RAW_DIV) begin
      raw_in = (div_q[16:0] > ONE_Q16) ? ONE_Q16 : div_q[16:0];
    end else begin
      raw_in = ONE_Q16;
    end

    fast_up   = raw_in > fast;
    fast_diff = fast_up ? (raw_in - fast) : (fast - raw_in);
    slow_up   = raw > slow;
    slow_diff = slow_up ? (raw - slow) : (slow - raw);

    delta    = prod[32:16];
    fast_upd = up ? (fast + delta) : (fast - delta);
    slow_upd = up ? (slow + delta) : (slow - delta);

    scaled     = prod[32:14];
    onset_gt   = {2'b0, fast} > scaled;
    onset_diff = 17'({2'b0, fast} - scaled);

    onset_raw = prod[32:12];
    onset_sat = (onset_raw > {4'b0, ONE_Q16}) ? ONE_Q16 : onset_raw[16:0];

    time_num = 18'(cnt) * 18'(MS_PER_S);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    emit_fire  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && chunk_end) begin
          state_next = ST_DEN;
        end
      end
      ST_DEN: begin
        if (step_done) begin
          state_next = raw_sat ? ST_FAST : ST_RAW_DIV;
        end
      end
      ST_RAW_DIV: if (step_done) state_next = ST_FAST;
      ST_FAST:    if (step_done) state_next = ST_SLOW;
      ST_SLOW:    if (step_done) state_next = ST_SCALE;
      ST_SCALE:   if (step_done) state_next = ST_ONSET;
      ST_ONSET:   if (step_done) state_next = ST_TIME;
      ST_TIME:    if (step_done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit_fire  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_divisor      <= NORM_DIVISOR_RST;
      fast_attack_coef  <= FAST_ATTACK_COEF_RST;
      fast_release_coef <= FAST_RELEASE_COEF_RST;
      slow_coef         <= SLOW_COEF_RST;
      onset_slow_scale  <= ONSET_SLOW_SCALE_RST;
      onset_gain        <= ONSET_GAIN_RST;
      acc               <= '0;
      cnt               <= '0;
      fast              <= '0;
      slow              <= '0;
      elapsed           <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_NORM_DIVISOR:      norm_divisor      <= cfg_data;
          CFG_FAST_ATTACK_COEF:  fast_attack_coef  <= cfg_data;
          CFG_FAST_RELEASE_COEF: fast_release_coef <= cfg_data;
          CFG_SLOW_COEF:         slow_coef         <= cfg_data;
          CFG_ONSET_SLOW_SCALE:  onset_slow_scale  <= cfg_data;
          CFG_ONSET_GAIN:        onset_gain        <= cfg_data;
          default: ;
        endcase
      end

      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // Multiplier steps: one bit of mul_b per cycle, least significant first.
      if (!step_done && (state == ST_DEN || state == ST_FAST || state == ST_SLOW ||
                         state == ST_SCALE || state == ST_ONSET)) begin
        prod  <= {mul_sum, prod[15:1]};
        mul_b <= mul_b >> 1;
        step  <= step - 5'd1;
      end

      // Divider steps: one quotient bit per cycle, most significant first.
      if (!step_done && (state == ST_RAW_DIV || state == ST_TIME)) begin
        div_r <= div_ge ? div_sub : div_sh;
        div_d <= div_d << 1;
        div_q <= {div_q[16:0], div_ge};
        step  <= step - 5'd1;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            acc <= acc_new;
            cnt <= cnt_new;
            if (sound_start) begin
              fast    <= '0;
              slow    <= '0;
              elapsed <= '0;
            end
            mul_a <= 17'(cnt_new);
            mul_b <= norm_divisor;
            prod  <= '0;
            step  <= MUL_STEPS;
          end
        end
        ST_DEN: begin
          if (step_done) begin
            if (raw_sat) begin
              raw   <= raw_in;
              up    <= fast_up;
              mul_a <= fast_diff;
              mul_b <= fast_up ? fast_attack_coef : fast_release_coef;
              prod  <= '0;
              step  <= MUL_STEPS;
            end else begin
              // Dividend is acc * 65536; the top part already lies below the divisor.
              div_v <= prod[23:0];
              div_r <= {3'b0, acc[22:1]};
              div_d <= {acc[0], 17'b0};
              div_q <= '0;
              step  <= DIV_RAW_STEPS;
            end
          end
        end
        ST_RAW_DIV: begin
          if (step_done) begin
            raw   <= raw_in;
            up    <= fast_up;
            mul_a <= fast_diff;
            mul_b <= fast_up ? fast_attack_coef : fast_release_coef;
            prod  <= '0;
            step  <= MUL_STEPS;
          end
        end
        ST_FAST: begin
          if (step_done) begin
            fast  <= fast_upd;
            up    <= slow_up;
            mul_a <= slow_diff;
            mul_b <= slow_coef;
            prod  <= '0;
            step  <= MUL_STEPS;
          end
        end
        ST_SLOW: begin
          if (step_done) begin
            slow  <= slow_upd;
            mul_a <= slow_upd;
            mul_b <= onset_slow_scale;
            prod  <= '0;
            step  <= MUL_STEPS;
          end
        end
        ST_SCALE: begin
          if (step_done) begin
            // A zero multiplicand gives zero onset when fast does not exceed scaled slow.
            mul_a <= onset_gt ? onset_diff : 17'd0;
            mul_b <= onset_gain;
            prod  <= '0;
            step  <= MUL_STEPS;
          end
        end
        ST_ONSET: begin
          if (step_done) begin
            onset <= onset_sat;
            div_v <= 24'(AUDIO_RATE_HZ);
            div_r <= '0;
            div_d <= time_num;
            div_q <= '0;
            step  <= DIV_TIME_STEPS;
          end
        end
        ST_TIME: begin
          if (step_done) begin
            elapsed <= elapsed + 32'(div_q);
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            level        <= slow;
            attack       <= onset;
            elapsed_time <= elapsed;
            acc          <= '0;
            cnt          <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
